### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, disabled while in reset
`define LMBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication check on the rising clock edge, disabled while in reset
`define LMBC_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

### hw/rtl/lmbc_pkg.sv
// types, constants and helper functions of the light mode button controller
package lmbc_pkg;

    localparam int PRESS_COUNT_BITS = 16;
    localparam int CFG_SHORT_W      = 16;
    localparam int TABLE_W          = 40;
    localparam int CMP_W            = (PRESS_COUNT_BITS > CFG_SHORT_W) ?
                                      PRESS_COUNT_BITS : CFG_SHORT_W;
    localparam int PADDR_W          = 6;
    localparam int PDATA_W          = 64;
    localparam int BRAKE_MODE_BIT   = 1;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_MIN_STEADY = 3'd0;
    localparam t_mode MODE_MAX_STEADY = 3'd1;
    localparam t_mode MODE_MIN_BRAKE  = 3'd2;
    localparam t_mode MODE_OFF_BRAKE  = 3'd3;
    localparam t_mode MODE_OFF        = 3'd4;

    localparam logic [PRESS_COUNT_BITS-1:0] PRESS_MAX = {PRESS_COUNT_BITS{1'b1}};
    localparam logic [7:0] FULL_DUTY = 8'hFF;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_LONG_PRESS   = 3'd0;
    localparam t_reg_idx REG_TILT_IGNORE  = 3'd1;
    localparam t_reg_idx REG_TILT_RELEASE = 3'd2;
    localparam t_reg_idx REG_TILT_BRAKE   = 3'd3;
    localparam t_reg_idx REG_DUTY_LOW     = 3'd4;
    localparam t_reg_idx REG_DUTY_HIGH    = 3'd5;

    localparam logic [CFG_SHORT_W-1:0] RST_LONG_PRESS   = 16'd400;
    localparam logic [CFG_SHORT_W-1:0] RST_TILT_IGNORE  = 16'd16368;
    localparam logic [CFG_SHORT_W-1:0] RST_TILT_RELEASE = 16'd4096;
    localparam logic [CFG_SHORT_W-1:0] RST_TILT_BRAKE   = 16'd12032;
    localparam logic [TABLE_W-1:0]     RST_DUTY_TABLE   = 40'h00_0080_FF80;

    typedef struct packed {
        logic [CFG_SHORT_W-1:0] long_press_ticks;
        logic [CFG_SHORT_W-1:0] tilt_ignore_above;
        logic [CFG_SHORT_W-1:0] tilt_release_level;
        logic [CFG_SHORT_W-1:0] tilt_brake_level;
        logic [TABLE_W-1:0]     duty_low_table;
        logic [TABLE_W-1:0]     duty_high_table;
    } t_cfg;

    typedef struct packed {
        logic        button_down;
        logic        tilt_valid;
        logic [15:0] tilt_reading;
    } t_in_beat;

    typedef struct packed {
        t_mode      light_mode;
        logic [7:0] duty_low;
        logic [7:0] duty_high;
        logic       brake_on;
        logic       long_press_seen;
        logic       short_press_seen;
    } t_out_beat;

    function automatic t_mode next_mode(input t_mode m);
        t_mode r;
        case (m)
            MODE_MIN_STEADY: r = MODE_MAX_STEADY;
            MODE_MAX_STEADY: r = MODE_MIN_BRAKE;
            MODE_MIN_BRAKE:  r = MODE_OFF_BRAKE;
            default:         r = MODE_MIN_STEADY;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] table_byte(input logic [TABLE_W-1:0] tbl, input t_mode m);
        logic [7:0] r;
        case (m)
            MODE_MIN_STEADY: r = tbl[7:0];
            MODE_MAX_STEADY: r = tbl[15:8];
            MODE_MIN_BRAKE:  r = tbl[23:16];
            MODE_OFF_BRAKE:  r = tbl[31:24];
            MODE_OFF:        r = tbl[39:32];
            default:         r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/lmbc_in_if.sv
// input channel interface carrying one tick beat
interface lmbc_in_if;
    logic               valid;
    logic               ready;
    lmbc_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/lmbc_out_if.sv
// output channel interface carrying one result beat
interface lmbc_out_if;
    logic                valid;
    logic                ready;
    lmbc_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/lmbc_cfg_regs.sv
// apb configuration registers
module lmbc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmbc_pkg::PADDR_W-1:0]  paddr,
    input  logic [lmbc_pkg::PDATA_W-1:0]  pwdata,
    output logic [lmbc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output lmbc_pkg::t_cfg                o_cfg
);

    lmbc_pkg::t_cfg     r_cfg;
    lmbc_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx  = paddr[lmbc_pkg::PADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks   <= lmbc_pkg::RST_LONG_PRESS;
            r_cfg.tilt_ignore_above  <= lmbc_pkg::RST_TILT_IGNORE;
            r_cfg.tilt_release_level <= lmbc_pkg::RST_TILT_RELEASE;
            r_cfg.tilt_brake_level   <= lmbc_pkg::RST_TILT_BRAKE;
            r_cfg.duty_low_table     <= lmbc_pkg::RST_DUTY_TABLE;
            r_cfg.duty_high_table    <= lmbc_pkg::RST_DUTY_TABLE;
        end else if (w_wr) begin
            case (w_idx)
                lmbc_pkg::REG_LONG_PRESS: begin
                    r_cfg.long_press_ticks <= pwdata[lmbc_pkg::CFG_SHORT_W-1:0];
                end
                lmbc_pkg::REG_TILT_IGNORE: begin
                    r_cfg.tilt_ignore_above <= pwdata[lmbc_pkg::CFG_SHORT_W-1:0];
                end
                lmbc_pkg::REG_TILT_RELEASE: begin
                    r_cfg.tilt_release_level <= pwdata[lmbc_pkg::CFG_SHORT_W-1:0];
                end
                lmbc_pkg::REG_TILT_BRAKE: begin
                    r_cfg.tilt_brake_level <= pwdata[lmbc_pkg::CFG_SHORT_W-1:0];
                end
                lmbc_pkg::REG_DUTY_LOW: begin
                    r_cfg.duty_low_table <= pwdata[lmbc_pkg::TABLE_W-1:0];
                end
                lmbc_pkg::REG_DUTY_HIGH: begin
                    r_cfg.duty_high_table <= pwdata[lmbc_pkg::TABLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            lmbc_pkg::REG_LONG_PRESS:   prdata = lmbc_pkg::PDATA_W'(r_cfg.long_press_ticks);
            lmbc_pkg::REG_TILT_IGNORE:  prdata = lmbc_pkg::PDATA_W'(r_cfg.tilt_ignore_above);
            lmbc_pkg::REG_TILT_RELEASE: prdata = lmbc_pkg::PDATA_W'(r_cfg.tilt_release_level);
            lmbc_pkg::REG_TILT_BRAKE:   prdata = lmbc_pkg::PDATA_W'(r_cfg.tilt_brake_level);
            lmbc_pkg::REG_DUTY_LOW:     prdata = lmbc_pkg::PDATA_W'(r_cfg.duty_low_table);
            lmbc_pkg::REG_DUTY_HIGH:    prdata = lmbc_pkg::PDATA_W'(r_cfg.duty_high_table);
            default:                    prdata = '0;
        endcase
    end

endmodule

### hw/rtl/lmbc_core.sv
// button, power, mode and brake state with the per-tick update and duty lookup
module lmbc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  lmbc_pkg::t_in_beat  i_beat,
    input  lmbc_pkg::t_cfg      i_cfg,
    output lmbc_pkg::t_out_beat o_beat
);

    logic [lmbc_pkg::PRESS_COUNT_BITS-1:0] r_press, n_press, w_press_inc;
    logic [1:0]                            r_rel, n_rel;
    lmbc_pkg::t_mode                       r_mode, n_mode, r_saved, n_saved;
    logic                                  r_brake, n_brake;
    logic                                  w_long, w_short, w_full;
    logic [lmbc_pkg::CMP_W-1:0]            w_lpt;

    assign w_press_inc = r_press + 1'b1;
    assign w_lpt       = lmbc_pkg::CMP_W'(i_cfg.long_press_ticks);

    always_comb begin
        n_press = r_press;
        n_rel   = r_rel;
        n_mode  = r_mode;
        n_saved = r_saved;
        n_brake = r_brake;
        w_long  = 1'b0;
        w_short = 1'b0;

        if (i_beat.button_down) begin
            n_rel = '0;
            if (r_press != lmbc_pkg::PRESS_MAX) begin
                n_press = w_press_inc;
                if (lmbc_pkg::CMP_W'(w_press_inc) == w_lpt) begin
                    w_long = 1'b1;
                    if (r_mode == lmbc_pkg::MODE_OFF) begin
                        n_mode = r_saved;
                    end else begin
                        n_saved = r_mode;
                        n_mode  = lmbc_pkg::MODE_OFF;
                    end
                end
            end
        end else if (r_press != '0) begin
            if (r_rel != '0) begin
                if (lmbc_pkg::CMP_W'(r_press) < w_lpt) begin
                    w_short = 1'b1;
                    if (r_mode != lmbc_pkg::MODE_OFF) begin
                        n_mode = lmbc_pkg::next_mode(r_mode);
                    end
                end
                n_press = '0;
                n_rel   = '0;
            end else begin
                n_rel = r_rel + 2'd1;
            end
        end

        if (i_beat.tilt_valid && (i_beat.tilt_reading <= i_cfg.tilt_ignore_above)) begin
            if (i_beat.tilt_reading > i_cfg.tilt_release_level) begin
                if (i_beat.tilt_reading > i_cfg.tilt_brake_level) begin
                    n_brake = 1'b1;
                end
            end else begin
                n_brake = 1'b0;
            end
        end

        w_full = n_mode[lmbc_pkg::BRAKE_MODE_BIT] && n_brake;

        o_beat.light_mode       = n_mode;
        o_beat.duty_low         = w_full ? lmbc_pkg::FULL_DUTY :
                                  lmbc_pkg::table_byte(i_cfg.duty_low_table, n_mode);
        o_beat.duty_high        = w_full ? lmbc_pkg::FULL_DUTY :
                                  lmbc_pkg::table_byte(i_cfg.duty_high_table, n_mode);
        o_beat.brake_on         = n_brake;
        o_beat.long_press_seen  = w_long;
        o_beat.short_press_seen = w_short;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press <= '0;
            r_rel   <= '0;
            r_mode  <= lmbc_pkg::MODE_OFF;
            r_saved <= lmbc_pkg::MODE_MIN_STEADY;
            r_brake <= 1'b0;
        end else if (i_en) begin
            r_press <= n_press;
            r_rel   <= n_rel;
            r_mode  <= n_mode;
            r_saved <= n_saved;
            r_brake <= n_brake;
        end
    end

endmodule

### hw/rtl/light_mode_button_controller_top.sv
// light mode button controller: one result beat for each tick beat
//
// i_in carries one tick per beat (button level, tilt valid and tilt reading);
// o_out returns one beat per tick with mode, duty bytes, brake flag and the
// long and short press strobes. the apb port (psel ... pready) holds the
// press threshold, tilt limits and duty tables at byte address 8*index;
// pready is always high and writes land in the access cycle.
// a tick is captured in an input register; the state update and duty lookup
// run on it and land in the output register once that register can take a
// beat, one beat per cycle sustained while o_out.ready stays high.
// a stalled output holds its beat; the input register still takes one more
// tick, after which i_in.ready drops until o_out.ready returns.
// synchronous reset empties both registers, turns the light off, sets the
// remembered mode to min steady, clears brake and press counters and loads
// the register defaults.
`include "assert_macros.svh"

module light_mode_button_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lmbc_in_if.sink                       i_in,
    lmbc_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmbc_pkg::PADDR_W-1:0]  paddr,
    input  logic [lmbc_pkg::PDATA_W-1:0]  pwdata,
    output logic [lmbc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    lmbc_pkg::t_cfg      w_cfg;
    lmbc_pkg::t_in_beat  r_in_data;
    logic                r_in_valid;
    lmbc_pkg::t_out_beat r_out_data, w_result;
    logic                r_out_valid;
    logic                w_adv;

    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    lmbc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lmbc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_beat  (r_in_data),
        .i_cfg   (w_cfg),
        .o_beat  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_result;
        end
    end

    `LMBC_ASSERT_IMPL(a_press_excl, r_out_valid, !(r_out_data.long_press_seen && r_out_data.short_press_seen), "long and short press in one beat")
    `LMBC_ASSERT_IMPL(a_mode_range, r_out_valid, r_out_data.light_mode <= lmbc_pkg::MODE_OFF, "light mode out of range")
    `LMBC_ASSERT_IMPL(a_in_hold, r_in_valid && !w_adv, ##1 r_in_valid, "pending tick dropped")
    `LMBC_ASSERT_IMPL(a_out_hold, r_out_valid && !o_out.ready, ##1 (r_out_valid && $stable(r_out_data)), "stalled result changed")

endmodule
